// File: design/lgs_pkg.sv
package lgs_pkg;

  // Field widths of the configuration registers.
  localparam int BOARD_WIDTH_BITS  = 11;
  localparam int BOARD_HEIGHT_BITS = 16;

  // Configuration port layout and register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BOARD_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BOARD_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [BOARD_WIDTH_BITS-1:0]  BOARD_WIDTH_RESET  = 11'd1024;
  localparam logic [BOARD_HEIGHT_BITS-1:0] BOARD_HEIGHT_RESET = 16'd1024;

  // Smallest board side; two border cells plus one interior cell.
  localparam int MIN_SIDE = 3;

  // B3/S23 with the centre cell counted in the sum.
  localparam logic [3:0] BIRTH_SUM   = 4'd3;
  localparam logic [3:0] SURVIVE_SUM = 4'd4;

  // Output queue geometry.
  localparam int FIFO_PTR_BITS   = 2;
  localparam int OUT_FIFO_DEPTH  = 2 ** FIFO_PTR_BITS;
  localparam int FIFO_LEVEL_BITS = FIFO_PTR_BITS + 1;

  // One window column: bit 2 top row, bit 1 middle row, bit 0 bottom row.
  typedef logic [2:0] column_t;

  typedef struct packed {
    logic next_cell;
    logic last_cell;
  } result_t;

  typedef struct packed {
    logic                       full;
    logic [FIFO_LEVEL_BITS-1:0] level;
  } fifo_status_t;

  // Number of live cells in one column.
  function automatic logic [1:0] column_ones(column_t c);
    return 2'(c[0]) + 2'(c[1]) + 2'(c[2]);
  endfunction

  // Next state of the centre cell from the nine-cell sum.
  function automatic logic life_rule(logic [3:0] sum, logic centre);
    return (sum == BIRTH_SUM) || ((sum == SURVIVE_SUM) && centre);
  endfunction

endpackage

// File: design/lgs_cell_if.sv
interface lgs_cell_if;
  logic valid;
  logic ready;
  logic cell_in;

  modport source (output valid, output cell_in, input ready);
  modport sink (input valid, input cell_in, output ready);
endinterface

// File: design/lgs_result_if.sv
interface lgs_result_if;
  logic valid;
  logic ready;
  logic next_cell;
  logic last_cell;

  modport source (output valid, output next_cell, output last_cell, input ready);
  modport sink (input valid, input next_cell, input last_cell, output ready);
endinterface

// File: design/lgs_window_cell.sv
module lgs_window_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  lgs_pkg::column_t col_in,
  output lgs_pkg::column_t col_out,
  output logic [1:0]      ones
);
  import lgs_pkg::*;

  column_t col;

  // Each cell takes its neighbor's column whenever the window advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // Partial sum of this column, added up by the top level.
  assign ones = column_ones(col);

endmodule

// File: design/lgs_line_buffer.sv
module lgs_line_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [1:0]               rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_data,
  output logic                     cleared
);
  import lgs_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // Bit 0 holds the row two back, bit 1 the previous row.
  logic [1:0]    mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clear_addr;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [1:0]    mem_wd;

  // Clearing pass after reset, one address per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clear_addr <= clear_addr + AW'(1);
    end
  end

  // The clearing pass owns the write port until it is done.
  always_comb begin
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clear_addr;
      mem_wd = 2'b00;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign cleared = !clearing;

endmodule

// File: design/lgs_out_fifo.sv
module lgs_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lgs_pkg::result_t      push_data,
  input  logic                  pop,
  output logic                  valid,
  output lgs_pkg::result_t      data,
  output lgs_pkg::fifo_status_t status
);
  import lgs_pkg::*;

  result_t                    mem [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0]   head;
  logic [FIFO_PTR_BITS-1:0]   tail;
  logic [FIFO_LEVEL_BITS-1:0] level;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= tail + FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        head <= head + FIFO_PTR_BITS'(1);
      end
      level <= level + FIFO_LEVEL_BITS'(push) - FIFO_LEVEL_BITS'(pop);
    end
  end

  // Storage for results waiting on the receiver.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= push_data;
    end
  end

  assign valid        = (level != '0);
  assign data         = mem[head];
  assign status.level = level;
  assign status.full  = (level == FIFO_LEVEL_BITS'(OUT_FIFO_DEPTH));

endmodule

// File: design/life_generation_stencil_unit.sv
// One Game of Life generation (B3/S23) over a board with a dead border.
// Cells arrive on the cells channel in row-major order, one bit per
// transaction, including the border ring. For every interior cell the block
// sends one transaction on the results channel with its next value, and
// last_cell marks the final interior cell of the board. After the last cell
// of the last row the counts wrap and the next cell starts a new board.
// board_width and board_height are written through the cfg port between
// transactions; they take effect on the next cell.
// Throughput is one cell per clock while ready is high. The result of the
// transaction that completes a window passes the registered line buffer
// read, the window column cells and the output queue before it is visible.
// A four-entry output queue absorbs results; when the receiver stalls, ready
// on the cells channel drops once four results are queued or in flight, and
// no result is lost. Synchronous reset clears the counters, the window and
// the queue, and sets both board sides to 1024. The line buffer memory is
// then cleared one address per cycle while ready stays low.
module life_generation_stencil_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  lgs_cell_if.sink                           cells,
  lgs_result_if.source                       results
);
  import lgs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = BOARD_HEIGHT_BITS;

  logic [BOARD_WIDTH_BITS-1:0] board_width;
  logic [HW-1:0]               board_height;
  logic [CW-1:0]               last_col;
  logic [HW-1:0]               last_row;
  logic [CW-1:0]               column_count;
  logic [HW-1:0]               row_count;
  logic                        accept;
  logic                        emit;
  logic                        at_col_end;
  logic                        at_row_end;
  logic                        cleared;
  logic [FIFO_LEVEL_BITS-1:0]  credit;
  logic                        s1_valid;
  logic                        s1_emit;
  logic                        s1_last;
  logic                        s1_bot;
  logic [CW-1:0]               s1_col;
  logic [1:0]                  rd_data;
  logic                        s2_valid;
  logic                        s2_last;
  column_t                     col0;
  column_t                     col1;
  column_t                     col2;
  logic [1:0]                  ones0;
  logic [1:0]                  ones1;
  logic [1:0]                  ones2;
  logic [3:0]                  sum;
  result_t                     push_data;
  result_t                     out_data;
  fifo_status_t                fifo_status;
  logic                        out_valid;
  logic                        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      board_width  <= BOARD_WIDTH_RESET;
      board_height <= BOARD_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOARD_WIDTH:  board_width  <= cfg_data[BOARD_WIDTH_BITS-1:0];
        CFG_BOARD_HEIGHT: board_height <= cfg_data[HW-1:0];
      endcase
    end
  end

  // Last column and row index, with both sides at least MIN_SIDE and the width clamped to the buffer size.
  always_comb begin
    if (board_width < BOARD_WIDTH_BITS'(MIN_SIDE)) begin
      last_col = CW'(MIN_SIDE - 1);
    end else if (32'(board_width) > MAX_WIDTH) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(board_width - BOARD_WIDTH_BITS'(1));
    end
    if (board_height < HW'(MIN_SIDE)) begin
      last_row = HW'(MIN_SIDE - 1);
    end else begin
      last_row = board_height - HW'(1);
    end
  end

  // Each transaction that emits a result reserves a queue slot, so ready follows the credit.
  assign accept        = cells.valid && cells.ready;
  assign cells.ready   = cleared && (credit != FIFO_LEVEL_BITS'(OUT_FIFO_DEPTH));
  assign at_col_end    = (column_count >= last_col);
  assign at_row_end    = (row_count >= last_row);
  assign emit          = (row_count >= HW'(2)) && (column_count >= CW'(2));
  assign pop           = out_valid && results.ready;

  // Credit counts results queued or still in the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + FIFO_LEVEL_BITS'(accept && emit) - FIFO_LEVEL_BITS'(pop);
    end
  end

  // Column and row position of the incoming cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (at_col_end) begin
        column_count <= '0;
        row_count    <= at_row_end ? '0 : row_count + HW'(1);
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // First stage: wait for the line buffer read of this column.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit;
      s1_last <= at_row_end && at_col_end;
      s1_bot  <= cells.cell_in;
      s1_col  <= column_count;
    end
  end

  // Two row buffers; each column moves up one row as the new cell arrives.
  lgs_line_buffer #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buffer (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (rd_data),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data ({s1_bot, rd_data[1]}),
    .cleared (cleared)
  );

  // Window: three column cells, newest first, shifting once per cell.
  lgs_window_cell u_cell0 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_valid),
    .col_in  ({rd_data[0], rd_data[1], s1_bot}),
    .col_out (col0),
    .ones    (ones0)
  );

  lgs_window_cell u_cell1 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_valid),
    .col_in  (col0),
    .col_out (col1),
    .ones    (ones1)
  );

  lgs_window_cell u_cell2 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_valid),
    .col_in  (col1),
    .col_out (col2),
    .ones    (ones2)
  );

  // Second stage: the window now holds the full neighborhood.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_last <= s1_last;
    end
  end

  // Nine-cell sum and the life rule; the centre is the middle of the window.
  assign sum                 = 4'(ones0) + 4'(ones1) + 4'(ones2);
  assign push_data.next_cell = life_rule(sum, col1[1]);
  assign push_data.last_cell = s2_last;

  lgs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (push_data),
    .pop       (pop),
    .valid     (out_valid),
    .data      (out_data),
    .status    (fifo_status)
  );

  assign results.valid     = out_valid;
  assign results.next_cell = out_data.next_cell;
  assign results.last_cell = out_data.last_cell;

`ifndef SYNTHESIS
  // Credit never promises more slots than the queue has.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit <= FIFO_LEVEL_BITS'(OUT_FIFO_DEPTH))
    else $error("credit exceeds output queue depth");

  // Credit matches queued results plus those still in the pipeline.
  a_credit_tracks: assert property (@(posedge clk) disable iff (rst)
    credit == fifo_status.level + FIFO_LEVEL_BITS'(s1_valid && s1_emit)
              + FIFO_LEVEL_BITS'(s2_valid))
    else $error("credit out of step with pipeline and queue");

  // A result never arrives at a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> !fifo_status.full)
    else $error("push into full output queue");

  // No result can appear while the line buffer is still being cleared.
  a_quiet_clear: assert property (@(posedge clk) disable iff (rst)
    !cleared |-> !results.valid && !s1_valid)
    else $error("activity during line buffer clearing");
`endif

endmodule
